FILE: src/alp_pkg.sv
// Shared constants and types for the ambient light lux block.
// Holds the band coefficients, the serial divider request type and widths.
// No dependencies.
package alp_pkg;

	localparam int CNT_W   = 16;    // width of a raw light count
	localparam int COEF_W  = 13;    // width of a band coefficient
	localparam int PROD_W  = 31;    // signed width of vis*A - ir*B
	localparam int DVD_W   = 28;    // positive difference fits in 28 bits
	localparam int DVR_W   = 17;    // divisor width
	localparam int STEP_W  = 5;     // holds a step count up to DVD_W
	localparam int FLT_W   = 19;    // width of 3*old + 2*lux

	// Coefficients in units of 1e-5.
	localparam logic [COEF_W-1:0] BAND1_A = 13'd3040;
	localparam logic [COEF_W-1:0] BAND1_B = 13'd6200;
	localparam logic [COEF_W-1:0] BAND2_A = 13'd2240;
	localparam logic [COEF_W-1:0] BAND2_B = 13'd3100;
	localparam logic [COEF_W-1:0] BAND3_A = 13'd1280;
	localparam logic [COEF_W-1:0] BAND3_B = 13'd1530;
	localparam logic [COEF_W-1:0] BAND4_A = 13'd146;
	localparam logic [COEF_W-1:0] BAND4_B = 13'd112;

	localparam logic [DVR_W-1:0] LUX_SCALE = 17'd100000;
	localparam logic [DVR_W-1:0] FLT_DIV   = 17'd5;

	localparam logic [STEP_W-1:0] LUX_STEPS = 5'd28;
	localparam logic [STEP_W-1:0] FLT_STEPS = 5'd19;

	typedef struct packed {
		logic                    start;
		logic [DVD_W-1:0]        dividend;
		logic [DVR_W-1:0]        divisor;
		logic [STEP_W-1:0]       steps;
	} div_req_t;

endpackage

FILE: src/alp_mul.sv
// Bit-serial multiply-subtract: forms vis*A - ir*B one count bit per cycle.
// Depends on alp_pkg for widths.
module alp_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [alp_pkg::CNT_W-1:0]          vis,
	input  logic [alp_pkg::CNT_W-1:0]          ir,
	input  logic [alp_pkg::COEF_W-1:0]         coef_a,
	input  logic [alp_pkg::COEF_W-1:0]         coef_b,
	output logic                               done,
	output logic signed [alp_pkg::PROD_W-1:0]  product
);

	localparam int HI_W   = alp_pkg::PROD_W - alp_pkg::CNT_W;
	localparam int CNT_IW = $clog2(alp_pkg::CNT_W);

	logic                              busy_q;
	logic                              done_q;
	logic [CNT_IW-1:0]                 cnt_q;
	logic [alp_pkg::CNT_W-1:0]         vis_q;
	logic [alp_pkg::CNT_W-1:0]         ir_q;
	logic [alp_pkg::COEF_W-1:0]        a_q;
	logic [alp_pkg::COEF_W-1:0]        b_q;
	logic signed [HI_W-1:0]            hi_q;
	logic [alp_pkg::CNT_W-1:0]         lo_q;
	logic signed [HI_W-1:0]            digit;
	logic signed [HI_W-1:0]            sum;

	// The running high part stays within the coefficient range, so the sum
	// never overflows its width.
	always_comb begin
		digit = (vis_q[0] ? HI_W'(a_q) : '0) - (ir_q[0] ? HI_W'(b_q) : '0);
		sum   = hi_q + digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_IW'(alp_pkg::CNT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vis_q <= vis;
			ir_q  <= ir;
			a_q   <= coef_a;
			b_q   <= coef_b;
			hi_q  <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			vis_q <= vis_q >> 1;
			ir_q  <= ir_q >> 1;
			hi_q  <= sum >>> 1;
			lo_q  <= {sum[0], lo_q[alp_pkg::CNT_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

FILE: src/alp_div.sv
// Restoring serial divider: one quotient bit per cycle, MSB first.
// Shared by the lux scaling and the low-pass update. Depends on alp_pkg.
module alp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  alp_pkg::div_req_t           req,
	output logic                        done,
	output logic [alp_pkg::DVD_W-1:0]   quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [alp_pkg::STEP_W-1:0]    cnt_q;
	logic [alp_pkg::STEP_W-1:0]    last_q;
	logic [alp_pkg::DVD_W-1:0]     dvd_q;
	logic [alp_pkg::DVR_W-1:0]     dvr_q;
	logic [alp_pkg::DVR_W-1:0]     rem_q;
	logic [alp_pkg::DVD_W-1:0]     quo_q;
	logic [alp_pkg::DVR_W:0]       trial;
	logic [alp_pkg::DVR_W:0]       diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, dvd_q[alp_pkg::DVD_W-1]};
		diff  = trial - {1'b0, dvr_q};
		ge    = trial >= {1'b0, dvr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dvr_q  <= req.divisor;
			last_q <= req.steps - 1'b1;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[alp_pkg::DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[alp_pkg::DVR_W-1:0] : trial[alp_pkg::DVR_W-1:0];
			quo_q <= {quo_q[alp_pkg::DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/ambient_lux_with_lowpass_top.sv
// Ambient light lux with a one-pole low-pass filter, digit-serial datapath.
// Each accepted item passes through the multiply, the lux divide and the filter
// divide in turn, then waits in ST_DONE until the output register is free; one
// item at a time, so no new item is taken until that result has left the sequencer.
// The bit-serial multiplier and the shared serial divider set the pace.
// Reset (arst_n low) clears the sequencer, the output valid and the level to 0.
module ambient_lux_with_lowpass_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [alp_pkg::CNT_W-1:0]   vis_ir_count,
	input  logic [alp_pkg::CNT_W-1:0]   ir_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [alp_pkg::CNT_W-1:0]   lux_now,
	output logic [alp_pkg::CNT_W-1:0]   lux_smoothed
);

	// Sequencer states. The block works on one item at a time; the output
	// register lets a new item start while the previous result waits.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DLUX = 3'd2;
	localparam logic [2:0] ST_DFLT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam int XW = 23;

	logic [2:0]                        state_q;
	logic                              mul_start;
	logic [alp_pkg::COEF_W-1:0]        coef_a;
	logic [alp_pkg::COEF_W-1:0]        coef_b;
	logic                              mul_done;
	logic signed [alp_pkg::PROD_W-1:0] product;
	alp_pkg::div_req_t                 div_req;
	logic                              div_done;
	logic [alp_pkg::DVD_W-1:0]         quotient;
	logic [alp_pkg::CNT_W-1:0]         lux_clamped;
	logic [alp_pkg::CNT_W-1:0]         lux_q;
	logic [alp_pkg::CNT_W-1:0]         level_q;
	logic [alp_pkg::FLT_W-1:0]         flt_num;
	logic                              out_valid_q;
	logic [alp_pkg::CNT_W-1:0]         out_lux_q;
	logic [alp_pkg::CNT_W-1:0]         out_lvl_q;
	logic                              in_accept;
	logic                              out_free;
	logic [XW-1:0]                     vis_x;
	logic [XW-1:0]                     ir_x;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign mul_start = in_accept;

	// Band selection by exact cross-multiplication against small constants.
	// A sample with no visible count, or a ratio above the last band, gets
	// zero coefficients so that the difference and the lux both come out 0.
	always_comb begin
		vis_x = XW'(vis_ir_count);
		ir_x  = XW'(ir_count);
		if (vis_ir_count == '0) begin
			coef_a = '0;
			coef_b = '0;
		end else if ((ir_x << 1) <= vis_x) begin
			coef_a = alp_pkg::BAND1_A;
			coef_b = alp_pkg::BAND1_B;
		end else if (ir_x * XW'(100) <= vis_x * XW'(61)) begin
			coef_a = alp_pkg::BAND2_A;
			coef_b = alp_pkg::BAND2_B;
		end else if (ir_x * XW'(5) <= vis_x * XW'(4)) begin
			coef_a = alp_pkg::BAND3_A;
			coef_b = alp_pkg::BAND3_B;
		end else if (ir_x * XW'(10) <= vis_x * XW'(13)) begin
			coef_a = alp_pkg::BAND4_A;
			coef_b = alp_pkg::BAND4_B;
		end else begin
			coef_a = '0;
			coef_b = '0;
		end
	end

	alp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.vis     (vis_ir_count),
		.ir      (ir_count),
		.coef_a  (coef_a),
		.coef_b  (coef_b),
		.done    (mul_done),
		.product (product)
	);

	// A quotient too wide for 16 bits saturates. With 16-bit counts it cannot
	// happen, but the clamp costs only a few gates.
	assign lux_clamped = (quotient[alp_pkg::DVD_W-1:alp_pkg::CNT_W] != '0)
		? '1 : quotient[alp_pkg::CNT_W-1:0];

	// The filter numerator 3*old + 2*lux, built as shifts and adds.
	assign flt_num = alp_pkg::FLT_W'({level_q, 1'b0}) + alp_pkg::FLT_W'(level_q)
		+ alp_pkg::FLT_W'({lux_clamped, 1'b0});

	// The divider is requested twice per item: once to scale the difference
	// by 1e-5 (negative differences are fed as zero), then to divide the
	// filter numerator by five. The filter numerator is left-aligned so that
	// only its own 19 bits need a step each.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = alp_pkg::LUX_SCALE;
		div_req.steps    = alp_pkg::LUX_STEPS;
		if (state_q == ST_MUL && mul_done) begin
			div_req.start    = 1'b1;
			div_req.dividend = product[alp_pkg::PROD_W-1] ? '0
				: product[alp_pkg::DVD_W-1:0];
		end else if (state_q == ST_DLUX && div_done) begin
			div_req.start    = 1'b1;
			div_req.dividend = {flt_num, (alp_pkg::DVD_W - alp_pkg::FLT_W)'(0)};
			div_req.divisor  = alp_pkg::FLT_DIV;
			div_req.steps    = alp_pkg::FLT_STEPS;
		end
	end

	alp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DLUX;
					end
				end
				ST_DLUX: begin
					if (div_done) begin
						state_q <= ST_DFLT;
					end
				end
				ST_DFLT: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// The divider holds its quotient, so the result can wait
					// here until the output register frees up.
					if (out_free) begin
						level_q     <= quotient[alp_pkg::CNT_W-1:0];
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DLUX && div_done) begin
			lux_q <= lux_clamped;
		end
		if (state_q == ST_DONE && out_free) begin
			out_lux_q <= lux_q;
			out_lvl_q <= quotient[alp_pkg::CNT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign lux_now      = out_lux_q;
	assign lux_smoothed = out_lvl_q;

	// An accepted item always starts the multiplier.
	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_MUL)
		else $error("accepted item did not start the multiplier");

	// The multiplier only finishes while the sequencer waits for it.
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier finished outside its state");

	// The divider only finishes during one of its two passes.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DLUX || state_q == ST_DFLT))
		else $error("divider finished outside its passes");

	// A presented result always carries the current filter level.
	a_level_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid && lux_smoothed == level_q)
		else $error("presented level differs from the filter state");

endmodule

FILE: verif/ambient_lux_with_lowpass_top_test.sv
// Self-checking testbench for ambient_lux_with_lowpass_top: lux bands, clamping and smoothing.
// Relies on alp_pkg for the count width and on the RTL under src; needs no other files.
`timescale 1ns / 100ps

module ambient_lux_with_lowpass_top_test;

	typedef logic [alp_pkg::CNT_W-1:0] count_t;

	// One result item as the block should present it.
	typedef struct {
		count_t lux_now;
		count_t lux_smoothed;
	} lux_reading_t;

	// The scoreboard keeps its own copy of the low-pass level. Every accepted
	// item is turned into the reading it must produce, and every result item
	// is checked against the oldest reading still waiting.
	class lux_scoreboard;
		lux_reading_t pending_readings[$];
		count_t       level;
		int           errors;

		function new();
			level  = '0;
			errors = 0;
		endfunction

		// Illuminance of one sample. The ratio ir/vis picks a band by exact
		// cross-multiplication; coefficients are in units of 1e-5.
		function count_t lux_from_counts(count_t vis, count_t ir);
			longint v, r, coef_a, coef_b, diff, whole;
			v = vis;
			r = ir;
			if (v == 0)
				return '0;
			if (2 * r <= v) begin
				coef_a = 3040;
				coef_b = 6200;
			end else if (100 * r <= 61 * v) begin
				coef_a = 2240;
				coef_b = 3100;
			end else if (5 * r <= 4 * v) begin
				coef_a = 1280;
				coef_b = 1530;
			end else if (10 * r <= 13 * v) begin
				coef_a = 146;
				coef_b = 112;
			end else begin
				return '0;
			end
			diff = v * coef_a - r * coef_b;
			if (diff <= 0)
				return '0;
			whole = diff / 100000;
			if (whole > 65535)
				return '1;
			return count_t'(whole);
		endfunction

		function count_t next_level(count_t old_level, count_t lux);
			int sum;
			sum = 3 * int'(old_level) + 2 * int'(lux);
			return count_t'(sum / 5);
		endfunction

		function void note_sample(count_t vis, count_t ir);
			lux_reading_t reading;
			reading.lux_now      = lux_from_counts(vis, ir);
			level                = next_level(level, reading.lux_now);
			reading.lux_smoothed = level;
			pending_readings.push_back(reading);
		endfunction

		function void check_reading(count_t lux, count_t smoothed);
			lux_reading_t reading;
			if (pending_readings.size() == 0) begin
				errors++;
				$error("result item with no item pending: lux_now %0d lux_smoothed %0d",
					lux, smoothed);
				return;
			end
			reading = pending_readings.pop_front();
			if (lux !== reading.lux_now) begin
				errors++;
				$error("lux_now: expected %0d, got %0d", reading.lux_now, lux);
			end
			if (smoothed !== reading.lux_smoothed) begin
				errors++;
				$error("lux_smoothed: expected %0d, got %0d", reading.lux_smoothed, smoothed);
			end
		endfunction

		function int outstanding();
			return pending_readings.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	count_t vis_ir_count;
	count_t ir_count;
	logic   out_valid;
	logic   out_stall = 1'b0;
	count_t lux_now;
	count_t lux_smoothed;

	// Chance, in percent, that the sender or the receiver idles on a given cycle.
	int send_idle_pct;
	int recv_idle_pct;

	lux_scoreboard board = new();

	ambient_lux_with_lowpass_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vis_ir_count (vis_ir_count),
		.ir_count     (ir_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.lux_now      (lux_now),
		.lux_smoothed (lux_smoothed)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random. The stall is registered, so it changes
	// only right after a rising edge and is stable when the block samples it.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Both handshakes are watched from one process. Values read here are
	// those from before the edge, which are the ones the block acted on. The
	// result is checked before the new item is noted so that a result can
	// never be matched against an item accepted at the same edge.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			board.check_reading(lux_now, lux_smoothed);
		if (in_valid === 1'b1 && in_stall === 1'b0)
			board.note_sample(vis_ir_count, ir_count);
	end

	// Offers one item, after a random number of idle cycles, and returns at
	// the edge where the block takes it. The valid stays high on return, so
	// a following item can be offered at once without a glitch.
	task automatic send_sample(input count_t vis, input count_t ir);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		vis_ir_count <= vis;
		ir_count     <= ir;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	// Stops sending and waits until every result that is owed has come back.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.outstanding() != 0);
	endtask

	// Random counts. Most pairs are aimed at the band limits and at ratios
	// inside the four bands, since uniform counts land above the top limit
	// far too often. The rest are uniform or tiny counts.
	task automatic random_pair(output count_t vis, output count_t ir);
		int kind, v, r, pct, num, den;
		kind = $urandom_range(9);
		v    = $urandom_range(65535);
		if (kind < 3) begin
			r = $urandom_range(65535);
		end else if (kind < 7) begin
			pct = $urandom_range(140);
			r   = v * pct / 100 + $urandom_range(3) - 1;
		end else if (kind < 9) begin
			case ($urandom_range(3))
				0: begin num = 1;  den = 2;   end
				1: begin num = 61; den = 100; end
				2: begin num = 4;  den = 5;   end
				default: begin num = 13; den = 10; end
			endcase
			r = v * num / den + $urandom_range(2) - 1;
		end else begin
			v = $urandom_range(15);
			r = $urandom_range(15);
		end
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		vis = count_t'(v);
		ir  = count_t'(r);
	endtask

	task automatic run_random(input int count);
		count_t vis, ir;
		repeat (count) begin
			random_pair(vis, ir);
			send_sample(vis, ir);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		vis_ir_count  = '0;
		ir_count      = '0;
		send_idle_pct = 18;
		recv_idle_pct = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items. Corners of both counts come first, including a zero
		// visible count. Then each band limit is hit exactly and just past it,
		// where the first limit also gives a negative difference that must
		// clamp to zero. A ratio above the top limit gives zero lux. Repeated
		// full-scale samples drive the filter up.
		send_sample(16'd0,     16'd0);
		send_sample(16'd0,     16'd65535);
		send_sample(16'd65535, 16'd0);
		send_sample(16'd65535, 16'd65535);
		send_sample(16'd1,     16'd0);
		send_sample(16'd1,     16'd65535);
		send_sample(16'd100,   16'd50);
		send_sample(16'd100,   16'd51);
		send_sample(16'd100,   16'd61);
		send_sample(16'd100,   16'd62);
		send_sample(16'd100,   16'd80);
		send_sample(16'd100,   16'd81);
		send_sample(16'd100,   16'd130);
		send_sample(16'd100,   16'd131);
		send_sample(16'd10000, 16'd13000);
		send_sample(16'd10000, 16'd13001);
		send_sample(16'd65535, 16'd32767);
		send_sample(16'd65535, 16'd39976);
		send_sample(16'd65535, 16'd52428);
		send_sample(16'd65535, 16'd1);
		send_sample(16'd65535, 16'd0);
		send_sample(16'd65535, 16'd0);
		hold_until_drained();

		// Random phase with a slow receiver, then with a slow sender, then
		// with no idling at all. The sender waits for every result between
		// phases.
		run_random(276);
		hold_until_drained();
		send_idle_pct = 50;
		recv_idle_pct = 18;
		run_random(276);
		hold_until_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(276);
		hold_until_drained();

		// Idle after draining, to catch any stray result item.
		repeat (80) @(posedge clk);
		if (board.errors == 0)
			$display("ambient_lux_with_lowpass_top: match");
		else
			$display("ambient_lux_with_lowpass_top: mismatch");
		$finish;
	end

	// A time limit far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("ambient_lux_with_lowpass_top: mismatch");
		$finish;
	end

endmodule
